/* sv/epc_pkg.sv */
package epc_pkg;

	localparam int TEXT_W     = 8;
	localparam int COUNT_W    = 32;
	localparam int PATTERN_W  = 64;
	localparam int LEN_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam logic [LEN_W-1:0] SEEN_LIMIT = 4'd15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES  = 1'b0,
		REG_PATTERN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic hit;
		logic before_letter;
	} win_status_t;

	function automatic logic is_letter(input logic [TEXT_W-1:0] c);
		is_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

/* sv/epc_window.sv */
module epc_window #(
	parameter int MAX_PATTERN = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic                          clear,
	input  logic [epc_pkg::TEXT_W-1:0]    text_byte,
	input  logic [epc_pkg::PATTERN_W-1:0] pattern,
	input  logic [epc_pkg::LEN_W-1:0]     len,
	output epc_pkg::win_status_t          status
);
	import epc_pkg::*;

	localparam int DEPTH = MAX_PATTERN + 1;
	localparam int IDX_W = $clog2(DEPTH);

	logic [TEXT_W-1:0] win_q [DEPTH];
	logic [TEXT_W-1:0] win_nxt [DEPTH];
	logic [LEN_W-1:0]  seen_q;
	logic [LEN_W-1:0]  seen_nxt;
	logic [IDX_W-1:0]  len_w;

	assign len_w = len[IDX_W-1:0];

	always_comb begin
		win_nxt[0] = text_byte;
		for (int i = 1; i < DEPTH; i++) begin
			win_nxt[i] = win_q[i-1];
		end
		seen_nxt = (seen_q < SEEN_LIMIT) ? seen_q + 4'd1 : seen_q;
	end

	always_comb begin
		logic [IDX_W-1:0] pos;
		pos = '0;
		status.hit = (seen_nxt >= len);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pos = len_w - IDX_W'(1) - IDX_W'(i);
			if (LEN_W'(i) < len && win_nxt[pos] != pattern[8*i +: 8]) begin
				status.hit = 1'b0;
			end
		end
		status.before_letter = (seen_nxt > len) && is_letter(win_nxt[len_w]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				win_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (shift) begin
			if (clear) begin
				for (int i = 0; i < DEPTH; i++) begin
					win_q[i] <= '0;
				end
				seen_q <= '0;
			end else begin
				win_q  <= win_nxt;
				seen_q <= seen_nxt;
			end
		end
	end

endmodule

/* sv/embedded_pattern_counter_top.sv */
// embedded pattern counter
// text arrives on the input channel one byte per transfer (in_valid / in_stall),
// with end_of_text set on the last byte. every occurrence of the configured
// pattern, overlaps included, counts when the byte before or after it is an
// ascii letter. on the last byte one result transfer carries match_count
// (saturating at 2^32-1) on out_valid / out_stall, and the text state clears.
// configuration (pattern_bytes at index 0, pattern_length at index 1) is written
// on cfg_valid / cfg_ready, which is always high; the user must write it only
// while the block is idle, as the block itself does not enforce this. a byte is
// registered in the input register; when a final byte leaves it, its count is
// registered in the output register. throughput is one byte per cycle, set by the
// combinational window compare and count update, unless a final byte waits.
// reset clears the window, the count and the output valid flag, and sets the
// pattern to zero with length one. while the receiver stalls, bytes that give no
// result keep flowing; a final byte waits in the input register and stalls the
// input until the pending result has been taken.
module embedded_pattern_counter_top #(
	parameter int MAX_PATTERN = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [epc_pkg::TEXT_W-1:0]      text_byte,
	input  logic                            end_of_text,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [epc_pkg::COUNT_W-1:0]     match_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [epc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [epc_pkg::PATTERN_W-1:0]   cfg_data
);
	import epc_pkg::*;

	logic [PATTERN_W-1:0] pattern_q;
	logic [LEN_W-1:0]     length_q;
	logic [LEN_W-1:0]     used_len;

	logic                 valid_s1;
	logic [TEXT_W-1:0]    byte_s1;
	logic                 last_s1;

	logic                 waiting_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   out_count_q;

	logic                 out_free;
	logic                 advance;
	win_status_t          win_status;
	logic                 inc_after;
	logic                 inc_before;
	logic [COUNT_W:0]     sum;
	logic [COUNT_W-1:0]   count_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		used_len = length_q;
		if (length_q == '0) begin
			used_len = 4'd1;
		end else if (length_q > LEN_W'(MAX_PATTERN)) begin
			used_len = LEN_W'(MAX_PATTERN);
		end
	end

	// transfer handshakes
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	epc_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (advance),
		.clear     (last_s1),
		.text_byte (byte_s1),
		.pattern   (pattern_q),
		.len       (used_len),
		.status    (win_status)
	);

	// count update, at most two increments per byte
	always_comb begin
		inc_after  = waiting_q && is_letter(byte_s1);
		inc_before = win_status.hit && win_status.before_letter;
		sum = {1'b0, count_q} + (COUNT_W+1)'(inc_after) + (COUNT_W+1)'(inc_before);
		count_nxt = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			count_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				waiting_q <= 1'b0;
				count_q   <= '0;
			end else begin
				waiting_q <= win_status.hit && !win_status.before_letter;
				count_q   <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_count_q <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = out_count_q;

endmodule

/* tb/sv/embedded_pattern_counter_top_tb.sv */
`timescale 1ns / 100ps

module embedded_pattern_counter_top_tb;
	import epc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1550;

	class count_board;
		logic [63:0] pat_chars;
		logic [3:0]  pat_len;
		logic [7:0]  window [9];
		logic [3:0]  seen;
		logic        waiting;
		logic [31:0] tally;
		logic [31:0] counts_due [$];
		int          errs;
		int          texts_done;

		function new();
			pat_chars = '0;
			pat_len = 4'd1;
			errs = 0;
			texts_done = 0;
			clear_text();
		endfunction

		static function int span(logic [3:0] l);
			if (l == 4'd0)
				return 1;
			if (l > 4'd8)
				return 8;
			return int'(l);
		endfunction

		static function bit alpha(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
		endfunction

		function void clear_text();
			foreach (window[i])
				window[i] = 8'h00;
			seen = 4'd0;
			waiting = 1'b0;
			tally = '0;
		endfunction

		function void bump();
			if (tally != COUNT_MAX)
				tally++;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [63:0] val);
			if (idx == REG_PATTERN_BYTES)
				pat_chars = val;
			else
				pat_len = val[3:0];
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			int n;
			bit hit;
			n = span(pat_len);
			if (waiting) begin
				if (alpha(b))
					bump();
				waiting = 1'b0;
			end
			for (int i = 8; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			if (seen < SEEN_LIMIT)
				seen++;
			hit = (int'(seen) >= n);
			for (int i = 0; i < n; i++)
				if (window[n-1-i] != pat_chars[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				if (int'(seen) >= n + 1 && alpha(window[n]))
					bump();
				else if (!last)
					waiting = 1'b1;
			end
			if (last) begin
				counts_due.push_back(tally);
				texts_done++;
				clear_text();
			end
		endfunction

		function void check_count(logic [31:0] got);
			logic [31:0] want;
			if (counts_due.size() == 0) begin
				$error("match_count: no result due, got %0d", got);
				errs++;
			end else begin
				want = counts_due.pop_front();
				if (got !== want) begin
					$error("match_count: expected %0d, got %0d", want, got);
					errs++;
				end
			end
		endfunction

		function int pending();
			return counts_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [TEXT_W-1:0]     text_byte;
	logic                  end_of_text;
	logic                  out_valid;
	logic                  out_stall;
	logic [COUNT_W-1:0]    match_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [PATTERN_W-1:0]  cfg_data;

	count_board  board;
	logic [7:0]  text_q [$];
	logic [63:0] cur_pat;
	logic [3:0]  cur_len;
	bit          jitter_on;
	bit          long_hold_req;
	int          items;
	int          settings;
	int          cycles;
	logic [15:0] lens_written;

	logic [7:0] few_chars [5] = '{8'h61, 8'h62, 8'h41, 8'h20, 8'h30};
	logic [7:0] odd_chars [13] = '{8'h00, 8'h20, 8'h30, 8'h39, 8'h40, 8'h5b, 8'h60,
		8'h7b, 8'h7f, 8'h80, 8'hc1, 8'he1, 8'hff};

	embedded_pattern_counter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_count (match_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("embedded_pattern_counter_top_tb: errors");
		$finish;
	end

	// result side: check each transfer, then pick the next stall
	initial begin
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_count(match_count);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 299;
				out_stall <= 1'b1;
			end else if (jitter_on && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_byte(b, last);
		items++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) begin
			push_byte(text_q[i], i == text_q.size() - 1);
			if (jitter_on && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16))
					@(posedge clk);
			end
		end
	endtask

	// hold the input until every count is back, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] pat, input logic [63:0] len_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PATTERN_BYTES;
		cfg_data <= pat;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(REG_PATTERN_BYTES, pat);
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data <= len_word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(REG_PATTERN_LENGTH, len_word);
		cfg_valid <= 1'b0;
		cur_pat = pat;
		cur_len = len_word[3:0];
		lens_written[len_word[3:0]] = 1'b1;
		settings++;
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? 8'h41 + c : 8'h61 + c;
	endfunction

	task automatic build_text();
		int n, chunks, k;
		text_q.delete();
		n = count_board::span(cur_len);
		chunks = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
		repeat (chunks) begin
			case ($urandom_range(0, 7))
				0, 1: begin
					for (int j = 0; j < n; j++)
						text_q.push_back(cur_pat[8*j +: 8]);
				end
				2: begin
					k = $urandom_range(1, n);
					for (int j = 0; j < k; j++)
						text_q.push_back(cur_pat[8*j +: 8]);
				end
				3: text_q.push_back(rand_letter());
				4: text_q.push_back(odd_chars[$urandom_range(0, 12)]);
				5: text_q.push_back(8'($urandom));
				6: text_q.push_back(few_chars[$urandom_range(0, 4)]);
				default: begin
					k = $urandom_range(0, n - 1);
					text_q.push_back(cur_pat[8*k +: 8]);
				end
			endcase
		end
	endtask

	task automatic random_setting(input int phase_no);
		logic [63:0] pat, len_word;
		logic [3:0] l;
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: begin
				for (int j = 0; j < 8; j++)
					pat[8*j +: 8] = few_chars[$urandom_range(0, 4)];
			end
			1: pat = {$urandom, $urandom};
			2: begin
				c = $urandom_range(0, 1) ? rand_letter() : odd_chars[$urandom_range(0, 12)];
				pat = {8{c}};
			end
			default: pat = $urandom_range(0, 1) ? 64'h0 : '1;
		endcase
		if ($urandom_range(0, 9) < 8)
			l = 4'($urandom_range(1, 8));
		else
			l = 4'($urandom_range(0, 15));
		if (phase_no == 0) begin
			pat = '1;
			l = 4'd8;
		end else if (phase_no == 1) begin
			l = 4'd1;
		end else if (phase_no == 4) begin
			l = 4'd15;
		end
		len_word = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'h0;
		len_word[3:0] = l;
		configure(pat, len_word);
	endtask

	initial begin
		int phase_no;
		board = new();
		arst_n = 1'b0;
		in_valid <= 1'b0;
		text_byte <= '0;
		end_of_text <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PATTERN_BYTES;
		cfg_data <= '0;
		jitter_on = 1'b0;
		long_hold_req = 1'b0;
		items = 0;
		settings = 0;
		lens_written = '0;
		cur_pat = '0;
		cur_len = 4'd1;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: one zero byte
		text_q = '{8'h00};
		send_text();
		text_q = '{8'h00, 8'h41};
		send_text();
		text_q = '{8'h7a, 8'h00};
		send_text();
		text_q = '{8'hff, 8'h00, 8'h7b};
		send_text();
		text_q = '{8'h40, 8'h00, 8'h5b, 8'h60, 8'h00, 8'h61};
		send_text();
		settle();

		// overlapping "aba"
		configure(64'h0000_0000_0061_6261, 64'd3);
		text_q = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h21};
		send_text();
		settle();

		// length code zero acts as one
		configure(64'hffff_ffff_ffff_ff5a, 64'd0);
		text_q = '{8'h5a, 8'h5a, 8'h5a};
		send_text();
		settle();

		phase_no = 0;
		while (items < ITEM_TARGET) begin
			random_setting(phase_no);
			jitter_on = (items < ITEM_TARGET - 250) && ($urandom_range(0, 3) != 0);
			if (phase_no == 2 || phase_no == 8)
				long_hold_req = 1'b1;
			repeat ($urandom_range(3, 12)) begin
				build_text();
				send_text();
			end
			settle();
			phase_no++;
		end
		jitter_on = 1'b0;
		settle();
		repeat (8)
			@(posedge clk);

		$display("covered %0d bytes in %0d texts under %0d pattern settings",
			items, board.texts_done, settings);
		$display("length codes written: %b", lens_written);
		if (board.errs == 0)
			$display("embedded_pattern_counter_top_tb: clean");
		else
			$display("embedded_pattern_counter_top_tb: errors");
		$finish;
	end

endmodule
